>>> src/arhd_pkg.sv
// ----------------------------------------------------------------------------
// arhd_pkg
// Shared types, S-box table and byte helpers for the AES round
// Hamming-distance power model.
// ----------------------------------------------------------------------------
package arhd_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    typedef enum logic [1:0]
    {
        REG_R1_LOW  = 2'd0,
        REG_R1_HIGH = 2'd1,
        REG_R2_LOW  = 2'd2,
        REG_R2_HIGH = 2'd3
    } arhd_reg_t;

    typedef struct packed
    {
        logic [127:0] round1;
        logic [127:0] round2;
    } arhd_keys_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
        8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
        8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
        8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
        8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
        8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
        8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
        8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
        8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
        8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
        8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
        8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
        8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
        8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
        8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
        8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
        8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
        8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
        8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
        8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
        8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
        8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
        8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
        8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
        8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
        8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
        8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
        8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
        8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
        8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
    };

    // ShiftRows: source byte s lands at s - 4*row (mod 16)
    function automatic logic [3:0] shift_dest(input logic [3:0] s);
        return s - {s[1:0], 2'b00};
    endfunction

    // inverse of shift_dest
    function automatic logic [3:0] shift_src(input logic [3:0] d);
        return d + {d[1:0], 2'b00};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

>>> src/arhd_regs.sv
// ----------------------------------------------------------------------------
// arhd_regs
// APB register file holding the assumed first and second round keys.
// ----------------------------------------------------------------------------
module arhd_regs
    import arhd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output arhd_keys_t        keys
);

    logic [63:0] r1_low_reg;
    logic [63:0] r1_high_reg;
    logic [63:0] r2_low_reg;
    logic [63:0] r2_high_reg;
    arhd_reg_t   reg_idx;
    logic        wr_en;

    assign reg_idx = arhd_reg_t'(paddr[4:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_low_reg  <= '0;
            r1_high_reg <= '0;
            r2_low_reg  <= '0;
            r2_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_R1_LOW:  r1_low_reg  <= pwdata;
                REG_R1_HIGH: r1_high_reg <= pwdata;
                REG_R2_LOW:  r2_low_reg  <= pwdata;
                REG_R2_HIGH: r2_high_reg <= pwdata;
                default:     r1_low_reg  <= r1_low_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_R1_LOW:  prdata = r1_low_reg;
            REG_R1_HIGH: prdata = r1_high_reg;
            REG_R2_LOW:  prdata = r2_low_reg;
            REG_R2_HIGH: prdata = r2_high_reg;
            default:     prdata = '0;
        endcase
    end

    assign keys.round1 = {r1_high_reg, r1_low_reg};
    assign keys.round2 = {r2_high_reg, r2_low_reg};

endmodule

>>> src/arhd_dist.sv
// ----------------------------------------------------------------------------
// arhd_dist
// Hypothesis datapath: round-1 S-box/ShiftRows, MixColumns, selected
// S-box lookup with the guessed key byte, and Hamming weight of the change.
// ----------------------------------------------------------------------------
module arhd_dist
    import arhd_pkg::*;
(
    input  logic [127:0] state,
    input  arhd_keys_t   keys,
    input  logic [7:0]   key_guess,
    input  logic [4:0]   byte_select,
    output logic [3:0]   distance
);

    logic [7:0] st  [16];
    logic [7:0] r1  [16];
    logic [7:0] mc  [16];
    logic [3:0] j;
    logic [3:0] p;
    logic [7:0] sb_in;
    logic [7:0] sb_out;
    logic [7:0] diff;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            st[i] = state[8*i +: 8];
        end
        for (int d = 0; d < 16; d++)
        begin
            r1[d] = SBOX[st[shift_src(4'(d))] ^ keys.round1[8*shift_src(4'(d)) +: 8]];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                mc[4*c+r] = r1[4*c+r]
                          ^ r1[4*c] ^ r1[4*c+1] ^ r1[4*c+2] ^ r1[4*c+3]
                          ^ xtime(r1[4*c+r] ^ r1[4*c+((r+1)%4)]);
            end
        end
    end

    assign j      = byte_select[3:0];
    assign p      = shift_dest(j);
    assign sb_in  = (byte_select[4] ? mc[j] : st[j]) ^ key_guess;
    assign sb_out = SBOX[sb_in];
    assign diff   = (byte_select[4] ? r1[p] : st[p]) ^ sb_out;
    assign distance = popcount8(diff);

endmodule

>>> src/aes_round_hamming_distance_model.sv
// ----------------------------------------------------------------------------
// aes_round_hamming_distance_model
// Power-model hypothesis for one AES trace per item: Hamming distance of a
// first- or second-round state byte under a guessed key byte.
//
//   channel   signals                          direction  payload
//   req       req_valid / req_ready            in         text, mask, guess, select
//   rsp       rsp_valid / rsp_ready            out        distance
//   apb       psel penable pwrite paddr ...    in/out     round keys, 64-bit regs
//
// One item per cycle sustained while rsp is ready; an item passes the input register, then the
// result register, with the single S-box/MixColumns/S-box path between them.
// Reset clears the round keys and both valid flags.
// A stall on rsp holds the result; req stays ready while a stage is free.
// ----------------------------------------------------------------------------
module aes_round_hamming_distance_model
    import arhd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [63:0]       text_low,
    input  logic [63:0]       text_high,
    input  logic [63:0]       chain_mask_low,
    input  logic [63:0]       chain_mask_high,
    input  logic [7:0]        key_guess,
    input  logic [4:0]        byte_select,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [3:0]        distance
);

    arhd_keys_t   keys;
    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic [127:0] state_reg;
    logic [7:0]   guess_reg;
    logic [4:0]   sel_reg;
    logic         rsp_valid_reg;
    logic         rsp_valid_next;
    logic [3:0]   distance_reg;
    logic [3:0]   distance_next;
    logic         advance;
    logic         req_fire;

    arhd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .keys    (keys)
    );

    arhd_dist u_dist
    (
        .state       (state_reg),
        .keys        (keys),
        .key_guess   (guess_reg),
        .byte_select (sel_reg),
        .distance    (distance_next)
    );

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || advance;
    assign req_fire  = req_valid && req_ready;

    assign s1_valid_next  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign rsp_valid_next = advance ? s1_valid_reg : rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            state_reg <= {text_high ^ chain_mask_high, text_low ^ chain_mask_low};
            guess_reg <= key_guess;
            sel_reg   <= byte_select;
        end
        if (advance && s1_valid_reg)
        begin
            distance_reg <= distance_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign distance  = distance_reg;

    a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> s1_valid_reg)
        else $error("accepted item not held in input stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(state_reg))
        else $error("input stage lost an item during stall");

    a_not_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> s1_valid_reg && rsp_valid_reg && !rsp_ready)
        else $error("req not ready with a free stage");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> distance_reg <= 4'd8)
        else $error("distance above 8");

    a_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> rsp_valid_reg)
        else $error("item in input stage did not reach result");

endmodule

>>> tb/sv/hypothesis_checker.sv
// ----------------------------------------------------------------------------
// hypothesis_checker
// Watches the register port and both item channels of the AES round
// Hamming-distance block. It keeps its own copy of the round keys and
// predicts each distance from an S-box built from the field inverse.
// Every result is compared in order, and register reads are checked too.
// ----------------------------------------------------------------------------
module hypothesis_checker
    import arhd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    input  logic              req_valid,
    input  logic              req_ready,
    input  logic [63:0]       text_low,
    input  logic [63:0]       text_high,
    input  logic [63:0]       chain_mask_low,
    input  logic [63:0]       chain_mask_high,
    input  logic [7:0]        key_guess,
    input  logic [4:0]        byte_select,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  logic [3:0]        distance,
    output int                fail_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]   sbox_lut [256];
    logic [127:0] round1_key;
    logic [127:0] round2_key;
    logic [63:0]  reg_value;
    logic [3:0]   want;
    logic [3:0]   expected_distance_q [$];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // x^254 is the field inverse (0 stays 0), then the affine map
    function automatic logic [7:0] sbox_entry(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] base;
        inv = 8'h01;
        base = x;
        for (int e = 0; e < 8; e++)
        begin
            if (e != 0)
                inv = gf_mul(inv, base);
            base = gf_mul(base, base);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                   ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic int row_shift_target(input int idx);
        return (idx + 16 - 4 * (idx % 4)) % 16;
    endfunction

    function automatic logic [3:0] hamming_hypothesis(
        input logic [127:0] text,
        input logic [127:0] mask,
        input logic [127:0] k1,
        input logic [127:0] k2,
        input logic [7:0]   guess,
        input logic [4:0]   sel
    );
        logic [7:0] st [16];
        logic [7:0] key1 [16];
        logic [7:0] key2 [16];
        logic [7:0] r1 [16];
        logic [7:0] mc [16];
        logic [7:0] r2 [16];
        logic [7:0] a0, a1, a2, a3, col_sum, diff;
        logic [3:0] ones;
        int j, p;
        for (int i = 0; i < 16; i++)
        begin
            st[i]   = text[8*i +: 8] ^ mask[8*i +: 8];
            key1[i] = k1[8*i +: 8];
            key2[i] = k2[8*i +: 8];
        end
        j = int'(sel[3:0]);
        p = row_shift_target(j);
        if (!sel[4])
            key1[j] = guess;
        for (int i = 0; i < 16; i++)
            r1[row_shift_target(i)] = sbox_lut[st[i] ^ key1[i]];
        if (!sel[4])
        begin
            diff = st[p] ^ r1[p];
        end
        else
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = r1[4*c];
                a1 = r1[4*c + 1];
                a2 = r1[4*c + 2];
                a3 = r1[4*c + 3];
                col_sum = a0 ^ a1 ^ a2 ^ a3;
                mc[4*c]     = a0 ^ col_sum ^ gf_mul(a0 ^ a1, 8'h02);
                mc[4*c + 1] = a1 ^ col_sum ^ gf_mul(a1 ^ a2, 8'h02);
                mc[4*c + 2] = a2 ^ col_sum ^ gf_mul(a2 ^ a3, 8'h02);
                mc[4*c + 3] = a3 ^ col_sum ^ gf_mul(a3 ^ a0, 8'h02);
            end
            key2[j] = guess;
            for (int i = 0; i < 16; i++)
                r2[row_shift_target(i)] = sbox_lut[mc[i] ^ key2[i]];
            diff = r1[p] ^ r2[p];
        end
        ones = 4'd0;
        for (int i = 0; i < 8; i++)
            ones = ones + 4'(diff[i]);
        return ones;
    endfunction

    initial
    begin
        for (int v = 0; v < 256; v++)
            sbox_lut[v] = sbox_entry(8'(v));
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round1_key = '0;
            round2_key = '0;
            fail_count = 0;
            outstanding = 0;
            expected_distance_q.delete();
        end
        else
        begin
            if (psel && penable && pready)
            begin
                case (arhd_reg_t'(paddr[ADDR_W-1:3]))
                    REG_R1_LOW:
                    begin
                        if (pwrite)
                            round1_key[63:0] = pwdata;
                        reg_value = round1_key[63:0];
                    end
                    REG_R1_HIGH:
                    begin
                        if (pwrite)
                            round1_key[127:64] = pwdata;
                        reg_value = round1_key[127:64];
                    end
                    REG_R2_LOW:
                    begin
                        if (pwrite)
                            round2_key[63:0] = pwdata;
                        reg_value = round2_key[63:0];
                    end
                    default:
                    begin
                        if (pwrite)
                            round2_key[127:64] = pwdata;
                        reg_value = round2_key[127:64];
                    end
                endcase
                if (!pwrite && prdata !== reg_value)
                begin
                    $error("prdata: expected %h, actual %h", reg_value, prdata);
                    fail_count++;
                end
            end

            if (req_valid && req_ready)
                expected_distance_q.push_back(hamming_hypothesis(
                    {text_high, text_low}, {chain_mask_high, chain_mask_low},
                    round1_key, round2_key, key_guess, byte_select));

            if (rsp_valid && rsp_ready)
            begin
                if (expected_distance_q.size() == 0)
                begin
                    $error("distance: expected no item, actual %0d", distance);
                    fail_count++;
                end
                else
                begin
                    want = expected_distance_q.pop_front();
                    if (distance !== want)
                    begin
                        $error("distance: expected %0d, actual %0d", want, distance);
                        fail_count++;
                    end
                end
            end
            outstanding = expected_distance_q.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the AES round Hamming-distance block: round keys
// are programmed and read back over the register port while idle, then
// directed and random trace items flow with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import arhd_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 92;

    logic              clk;
    logic              rst_n           = 1'b0;
    logic              psel            = 1'b0;
    logic              penable         = 1'b0;
    logic              pwrite          = 1'b0;
    logic [ADDR_W-1:0] paddr           = '0;
    logic [DATA_W-1:0] pwdata          = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              req_valid       = 1'b0;
    logic              req_ready;
    logic [63:0]       text_low        = '0;
    logic [63:0]       text_high       = '0;
    logic [63:0]       chain_mask_low  = '0;
    logic [63:0]       chain_mask_high = '0;
    logic [7:0]        key_guess       = '0;
    logic [4:0]        byte_select     = '0;
    logic              rsp_valid;
    logic              rsp_ready       = 1'b0;
    logic [3:0]        distance;

    int fail_count;
    int outstanding;
    int sent_count   = 0;
    int taken_count  = 0;
    int stall_cycles = 0;

    aes_round_hamming_distance_model dut (.*);

    hypothesis_checker hd_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_item(
        input logic [63:0] t_lo,
        input logic [63:0] t_hi,
        input logic [63:0] m_lo,
        input logic [63:0] m_hi,
        input logic [7:0]  guess,
        input logic [4:0]  sel
    );
        int gap;
        gap = ((sent_count / 32) % 3 == 2) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid       <= 1'b1;
        text_low        <= t_lo;
        text_high       <= t_hi;
        chain_mask_low  <= m_lo;
        chain_mask_high <= m_hi;
        key_guess       <= guess;
        byte_select     <= sel;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        sent_count++;
    endtask

    // drop valid, then wait until every accepted item has come back
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_access(input logic is_write, input arhd_reg_t r,
                              input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_W'({r, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_round_keys(input logic [63:0] k1_lo, input logic [63:0] k1_hi,
                                      input logic [63:0] k2_lo, input logic [63:0] k2_hi);
        apb_access(1'b1, REG_R1_LOW, k1_lo);
        apb_access(1'b1, REG_R1_HIGH, k1_hi);
        apb_access(1'b1, REG_R2_LOW, k2_lo);
        apb_access(1'b1, REG_R2_HIGH, k2_hi);
        apb_access(1'b0, REG_R1_LOW, '0);
        apb_access(1'b0, REG_R1_HIGH, '0);
        apb_access(1'b0, REG_R2_LOW, '0);
        apb_access(1'b0, REG_R2_HIGH, '0);
    endtask

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = ((taken_count / 40) % 4 == 1) ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            taken_count++;
        end
    end

    initial
    begin
        logic [63:0] m_lo;
        logic [63:0] m_hi;
        int          mask_mode;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // keys at reset value
        send_item('0, '0, '0, '0, 8'h00, 5'd0);
        send_item('1, '1, '0, '0, 8'hff, 5'd15);
        send_item('0, '0, '1, '1, 8'h80, 5'd16);
        send_item('1, '1, '1, '1, 8'h01, 5'd31);
        send_item(64'h0123456789abcdef, 64'hfedcba9876543210, '0, '0, 8'h2b, 5'd5);
        send_item(64'h0123456789abcdef, 64'hfedcba9876543210,
                  64'h5a5aa5a5c3c33c3c, 64'h0ff0f00f96696996, 8'h7e, 5'd21);

        settle();
        program_round_keys('1, '1, '1, '1);
        send_item('0, '0, '0, '0, 8'hff, 5'd0);
        send_item('1, '0, '0, '0, 8'h00, 5'd15);
        send_item('0, '1, '0, '1, 8'hff, 5'd16);
        send_item('1, '1, '0, '0, 8'h00, 5'd31);

        // standard example key and its first expansion
        settle();
        program_round_keys(64'ha6d2ae2816157e2b, 64'h3c4fcf098815f7ab,
                           64'hb12c548817fefaa0, 64'h05766c2a3939a323);
        send_item(64'h8d305a88a8f64332, 64'h340737e0a2983131, '0, '0, 8'h2b, 5'd3);
        send_item(64'h8d305a88a8f64332, 64'h340737e0a2983131, '0, '0, 8'h7e, 5'd10);
        send_item(64'h8d305a88a8f64332, 64'h340737e0a2983131, '0, '0, 8'ha0, 5'd19);
        send_item(64'h8d305a88a8f64332, 64'h340737e0a2983131, '0, '0, 8'hfa, 5'd26);
        send_item(64'h8d305a88a8f64332, 64'h340737e0a2983131, '1, '0, 8'h00, 5'd12);
        send_item(64'h8d305a88a8f64332, 64'h340737e0a2983131, '0, '1, 8'hff, 5'd28);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            if (phase == 0)
                program_round_keys('0, '0, '0, '0);
            else if (phase == 1)
                program_round_keys('1, '1, '1, '1);
            else
                program_round_keys(rand64(), rand64(), rand64(), rand64());
            repeat (PHASE_ITEMS)
            begin
                mask_mode = $urandom_range(0, 2);
                m_lo = (mask_mode == 0) ? '0 : rand64();
                m_hi = (mask_mode == 0) ? '0 : rand64();
                send_item(rand64(), rand64(), m_lo, m_hi,
                          8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
